### hdl/affine_transform_bounding_box_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the affine transform bounding box block
// Short forms for clocked properties with an asynchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef AFFINE_TRANSFORM_BOUNDING_BOX_DEFINES_SVH
`define AFFINE_TRANSFORM_BOUNDING_BOX_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ATBB_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: property violated");

// The consequent must hold in the cycle after the antecedent.
`define ATBB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: property violated");

`endif

### hdl/atbb_pkg.sv
// ----------------------------------------------------------------------------
// atbb_pkg
// Widths, codes, reset values and the controller/datapath command types.
// ----------------------------------------------------------------------------
package atbb_pkg;

	localparam int DATA_W     = 32;
	localparam int COMP_W     = 16;
	localparam int AXIS_W     = 3 * COMP_W;
	localparam int PROD_W     = DATA_W + COMP_W;
	localparam int ACC_W      = PROD_W + 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = AXIS_W;
	localparam int AXIS_FRAC  = 14;
	localparam int SCALE_FRAC = 8;

	localparam logic [1:0] LAST_COMP = 2'd2;

	localparam logic [AXIS_W-1:0] X_AXIS_RESET = 48'h0000_0000_4000;
	localparam logic [AXIS_W-1:0] Y_AXIS_RESET = 48'h0000_4000_0000;
	localparam logic signed [COMP_W-1:0] UNIT_COMP  = 16'sh4000;
	localparam logic signed [COMP_W-1:0] SCALE_RESET = 16'sh0100;

	// 1000.0 and -1000.0 in Q16.16.
	localparam logic signed [DATA_W-1:0] INIT_MIN = 32'sh03E8_0000;
	localparam logic signed [DATA_W-1:0] INIT_MAX = -32'sh03E8_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_X_AXIS  = 3'd0,
		CFG_Y_AXIS  = 3'd1,
		CFG_SCALE   = 3'd2,
		CFG_SHIFT_X = 3'd3,
		CFG_SHIFT_Y = 3'd4,
		CFG_SHIFT_Z = 3'd5
	} cfg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL0,
		S_MUL1,
		S_MUL2,
		S_DRAIN,
		S_ROUND,
		S_SCALE,
		S_SDRAIN,
		S_SCALED,
		S_SHIFT,
		S_UPDATE,
		S_EMIT,
		S_CMUL0,
		S_CMUL1,
		S_CDRAIN,
		S_CROUND
	} state_t;

	typedef enum logic [2:0] {
		A_PX,
		A_PY,
		A_PZ,
		A_DOT,
		A_XAX
	} a_sel_t;

	typedef enum logic [1:0] {
		B_XAX,
		B_YAX,
		B_THIRD,
		B_SCALE
	} b_sel_t;

	typedef enum logic [1:0] {
		ACC_NONE,
		ACC_LOAD,
		ACC_ADD,
		ACC_SUB
	} acc_op_t;

	typedef struct packed {
		a_sel_t     a_sel;
		logic [1:0] a_comp;
		b_sel_t     b_sel;
		logic [1:0] b_comp;
		acc_op_t    acc_op;
		logic [1:0] coord;
		logic       item_ld;
		logic       dot_ld;
		logic       scl_ld;
		logic       res_ld;
		logic       bnd_upd;
		logic       third_ld;
		logic       emit;
	} atbb_cmd_t;

	typedef struct packed {
		logic final_vtx;
		logic out_busy;
	} atbb_status_t;

endpackage

### hdl/atbb_vertex_if.sv
// ----------------------------------------------------------------------------
// atbb_vertex_if
// Vertex channel: one Q16.16 vertex and its last-of-mesh mark per item.
// ----------------------------------------------------------------------------
interface atbb_vertex_if import atbb_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] vertex_x;
	logic signed [DATA_W-1:0] vertex_y;
	logic signed [DATA_W-1:0] vertex_z;
	logic                     final_vertex;

	modport source (output valid, output vertex_x, output vertex_y, output vertex_z,
		output final_vertex, input ready);
	modport sink (input valid, input vertex_x, input vertex_y, input vertex_z,
		input final_vertex, output ready);
endinterface

### hdl/atbb_box_if.sv
// ----------------------------------------------------------------------------
// atbb_box_if
// Result channel: the six bounds of one mesh per item.
// ----------------------------------------------------------------------------
interface atbb_box_if import atbb_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] low_x;
	logic signed [DATA_W-1:0] low_y;
	logic signed [DATA_W-1:0] low_z;
	logic signed [DATA_W-1:0] high_x;
	logic signed [DATA_W-1:0] high_y;
	logic signed [DATA_W-1:0] high_z;

	modport source (output valid, output low_x, output low_y, output low_z,
		output high_x, output high_y, output high_z, input ready);
	modport sink (input valid, input low_x, input low_y, input low_z,
		input high_x, input high_y, input high_z, output ready);
endinterface

### hdl/atbb_cfg_if.sv
// ----------------------------------------------------------------------------
// atbb_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface atbb_cfg_if import atbb_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### hdl/atbb_datapath.sv
// ----------------------------------------------------------------------------
// atbb_datapath
// Configuration registers, shared 32x16 multiplier, accumulator, rounding and
// saturation, running bounds and the result register.
// ----------------------------------------------------------------------------
module atbb_datapath import atbb_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  atbb_cmd_t                cmd,
	output atbb_status_t             status,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data,
	input  logic signed [DATA_W-1:0] in_x,
	input  logic signed [DATA_W-1:0] in_y,
	input  logic signed [DATA_W-1:0] in_z,
	input  logic                     in_final,
	input  logic                     out_ready,
	output logic                     out_valid,
	output logic signed [DATA_W-1:0] low [3],
	output logic signed [DATA_W-1:0] high [3]
);

	function automatic logic signed [COMP_W-1:0] comp_of(input logic [AXIS_W-1:0] axis,
			input logic [1:0] idx);
		logic signed [COMP_W-1:0] c;
		case (idx)
			2'd0:    c = axis[COMP_W-1:0];
			2'd1:    c = axis[2*COMP_W-1:COMP_W];
			default: c = axis[3*COMP_W-1:2*COMP_W];
		endcase
		return c;
	endfunction

	// Add half an LSB, then arithmetic shift (floor).
	function automatic logic signed [ACC_W-1:0] round_shift(input logic signed [ACC_W-1:0] v,
			input int unsigned k);
		logic signed [ACC_W-1:0] t;
		t = v + (ACC_W'(1) << (k - 1));
		return t >>> k;
	endfunction

	function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [ACC_W-1:0] v);
		logic signed [DATA_W-1:0] r;
		if (v[ACC_W-1:DATA_W-1] == '0 || v[ACC_W-1:DATA_W-1] == '1) begin
			r = v[DATA_W-1:0];
		end else if (v[ACC_W-1]) begin
			r = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(DATA_W-1){1'b1}}};
		end
		return r;
	endfunction

	function automatic logic signed [COMP_W-1:0] sat_comp(input logic signed [ACC_W-1:0] v);
		logic signed [COMP_W-1:0] r;
		if (v[ACC_W-1:COMP_W-1] == '0 || v[ACC_W-1:COMP_W-1] == '1) begin
			r = v[COMP_W-1:0];
		end else if (v[ACC_W-1]) begin
			r = {1'b1, {(COMP_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(COMP_W-1){1'b1}}};
		end
		return r;
	endfunction

	logic [AXIS_W-1:0]        x_axis_q;
	logic [AXIS_W-1:0]        y_axis_q;
	logic signed [COMP_W-1:0] third_q [3];
	logic signed [COMP_W-1:0] scale_q;
	logic signed [DATA_W-1:0] shift_q [3];

	logic signed [DATA_W-1:0] vtx_q [3];
	logic                     final_q;

	logic signed [DATA_W-1:0] a_op;
	logic signed [COMP_W-1:0] b_op;
	logic signed [PROD_W-1:0] prod_w;
	logic signed [PROD_W-1:0] prod_s1;
	acc_op_t                  acc_op_s1;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  prod_ext;

	logic signed [DATA_W-1:0] dot_q;
	logic signed [DATA_W-1:0] scl_q;
	logic signed [DATA_W-1:0] res_q;
	logic signed [DATA_W:0]   shift_sum;
	logic signed [DATA_W-1:0] min_q [3];
	logic signed [DATA_W-1:0] max_q [3];
	logic                     out_valid_q;

	// Configuration registers and the derived third axis.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_axis_q   <= X_AXIS_RESET;
			y_axis_q   <= Y_AXIS_RESET;
			third_q[0] <= '0;
			third_q[1] <= '0;
			third_q[2] <= UNIT_COMP;
			scale_q    <= SCALE_RESET;
			shift_q[0] <= '0;
			shift_q[1] <= '0;
			shift_q[2] <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_X_AXIS:  x_axis_q   <= cfg_data;
					CFG_Y_AXIS:  y_axis_q   <= cfg_data;
					CFG_SCALE:   scale_q    <= cfg_data[COMP_W-1:0];
					CFG_SHIFT_X: shift_q[0] <= cfg_data[DATA_W-1:0];
					CFG_SHIFT_Y: shift_q[1] <= cfg_data[DATA_W-1:0];
					CFG_SHIFT_Z: shift_q[2] <= cfg_data[DATA_W-1:0];
					default: ;
				endcase
			end
			if (cmd.third_ld) begin
				third_q[cmd.coord] <= sat_comp(round_shift(acc_q, AXIS_FRAC));
			end
		end
	end

	always_comb begin
		case (cmd.a_sel)
			A_PX:    a_op = vtx_q[0];
			A_PY:    a_op = vtx_q[1];
			A_PZ:    a_op = vtx_q[2];
			A_DOT:   a_op = dot_q;
			default: a_op = DATA_W'(comp_of(x_axis_q, cmd.a_comp));
		endcase
		case (cmd.b_sel)
			B_XAX:   b_op = comp_of(x_axis_q, cmd.b_comp);
			B_YAX:   b_op = comp_of(y_axis_q, cmd.b_comp);
			B_THIRD: b_op = third_q[cmd.b_comp];
			default: b_op = scale_q;
		endcase
	end

	assign prod_w    = a_op * b_op;
	assign prod_ext  = {{(ACC_W-PROD_W){prod_s1[PROD_W-1]}}, prod_s1};
	assign shift_sum = {scl_q[DATA_W-1], scl_q} + {shift_q[cmd.coord][DATA_W-1],
		shift_q[cmd.coord]};

	// Payload registers: no reset needed.
	always_ff @(posedge clk) begin
		if (cmd.item_ld) begin
			vtx_q[0] <= in_x;
			vtx_q[1] <= in_y;
			vtx_q[2] <= in_z;
			final_q  <= in_final;
		end
		prod_s1 <= prod_w;
		case (acc_op_s1)
			ACC_LOAD: acc_q <= prod_ext;
			ACC_ADD:  acc_q <= acc_q + prod_ext;
			ACC_SUB:  acc_q <= acc_q - prod_ext;
			default:  ;
		endcase
		if (cmd.dot_ld) begin
			dot_q <= sat_data(round_shift(acc_q, AXIS_FRAC));
		end
		if (cmd.scl_ld) begin
			scl_q <= sat_data(round_shift(acc_q, SCALE_FRAC));
		end
		if (cmd.res_ld) begin
			if (shift_sum[DATA_W] != shift_sum[DATA_W-1]) begin
				res_q <= shift_sum[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}}
					: {1'b0, {(DATA_W-1){1'b1}}};
			end else begin
				res_q <= shift_sum[DATA_W-1:0];
			end
		end
		if (cmd.emit) begin
			for (int i = 0; i < 3; i++) begin
				low[i]  <= min_q[i];
				high[i] <= max_q[i];
			end
		end
	end

	// Running bounds, product tag and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_op_s1   <= ACC_NONE;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				min_q[i] <= INIT_MIN;
				max_q[i] <= INIT_MAX;
			end
		end else begin
			acc_op_s1 <= cmd.acc_op;
			if (cmd.bnd_upd) begin
				if (res_q < min_q[cmd.coord]) begin
					min_q[cmd.coord] <= res_q;
				end
				if (res_q > max_q[cmd.coord]) begin
					max_q[cmd.coord] <= res_q;
				end
			end
			if (cmd.emit) begin
				for (int i = 0; i < 3; i++) begin
					min_q[i] <= INIT_MIN;
					max_q[i] <= INIT_MAX;
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign status.final_vtx = final_q;
	assign status.out_busy  = out_valid_q && !out_ready;

endmodule

### hdl/atbb_controller.sv
// ----------------------------------------------------------------------------
// atbb_controller
// Sequencer for the transform of one vertex and for the cross product.
// ----------------------------------------------------------------------------
module atbb_controller import atbb_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	output logic                 cfg_ready,
	input  atbb_status_t         status,
	output atbb_cmd_t            cmd
);

	// Component index c + off, modulo three.
	function automatic logic [1:0] rot_comp(input logic [1:0] c, input logic [1:0] off);
		logic [2:0] s;
		s = {1'b0, c} + {1'b0, off};
		if (s >= 3'd3) begin
			s = s - 3'd3;
		end
		return s[1:0];
	endfunction

	state_t     state_q, state_nx;
	logic [1:0] coord_q, coord_nx;
	logic       axis_wr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			coord_q <= '0;
		end else begin
			state_q <= state_nx;
			coord_q <= coord_nx;
		end
	end

	assign axis_wr = cfg_valid && (cfg_idx_t'(cfg_index) == CFG_X_AXIS ||
		cfg_idx_t'(cfg_index) == CFG_Y_AXIS);

	always_comb begin
		state_nx     = state_q;
		coord_nx     = coord_q;
		in_ready     = 1'b0;
		cfg_ready    = 1'b0;
		cmd.a_sel    = A_PX;
		cmd.a_comp   = coord_q;
		cmd.b_sel    = B_XAX;
		cmd.b_comp   = coord_q;
		cmd.acc_op   = ACC_NONE;
		cmd.coord    = coord_q;
		cmd.item_ld  = 1'b0;
		cmd.dot_ld   = 1'b0;
		cmd.scl_ld   = 1'b0;
		cmd.res_ld   = 1'b0;
		cmd.bnd_upd  = 1'b0;
		cmd.third_ld = 1'b0;
		cmd.emit     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				cfg_ready   = 1'b1;
				in_ready    = !cfg_valid;
				cmd.item_ld = in_valid && !cfg_valid;
				if (axis_wr) begin
					coord_nx = '0;
					state_nx = S_CMUL0;
				end else if (in_valid && !cfg_valid) begin
					coord_nx = '0;
					state_nx = S_MUL0;
				end
			end
			S_MUL0: begin
				cmd.a_sel  = A_PX;
				cmd.b_sel  = B_XAX;
				cmd.acc_op = ACC_LOAD;
				state_nx   = S_MUL1;
			end
			S_MUL1: begin
				cmd.a_sel  = A_PY;
				cmd.b_sel  = B_YAX;
				cmd.acc_op = ACC_ADD;
				state_nx   = S_MUL2;
			end
			S_MUL2: begin
				cmd.a_sel  = A_PZ;
				cmd.b_sel  = B_THIRD;
				cmd.acc_op = ACC_ADD;
				state_nx   = S_DRAIN;
			end
			S_DRAIN: begin
				state_nx = S_ROUND;
			end
			S_ROUND: begin
				cmd.dot_ld = 1'b1;
				state_nx   = S_SCALE;
			end
			S_SCALE: begin
				cmd.a_sel  = A_DOT;
				cmd.b_sel  = B_SCALE;
				cmd.acc_op = ACC_LOAD;
				state_nx   = S_SDRAIN;
			end
			S_SDRAIN: begin
				state_nx = S_SCALED;
			end
			S_SCALED: begin
				cmd.scl_ld = 1'b1;
				state_nx   = S_SHIFT;
			end
			S_SHIFT: begin
				cmd.res_ld = 1'b1;
				state_nx   = S_UPDATE;
			end
			S_UPDATE: begin
				cmd.bnd_upd = 1'b1;
				if (coord_q != LAST_COMP) begin
					coord_nx = coord_q + 2'd1;
					state_nx = S_MUL0;
				end else if (status.final_vtx) begin
					state_nx = S_EMIT;
				end else begin
					state_nx = S_IDLE;
				end
			end
			S_EMIT: begin
				if (!status.out_busy) begin
					cmd.emit = 1'b1;
					state_nx = S_IDLE;
				end
			end
			S_CMUL0: begin
				cmd.a_sel  = A_XAX;
				cmd.a_comp = rot_comp(coord_q, 2'd1);
				cmd.b_sel  = B_YAX;
				cmd.b_comp = rot_comp(coord_q, 2'd2);
				cmd.acc_op = ACC_LOAD;
				state_nx   = S_CMUL1;
			end
			S_CMUL1: begin
				cmd.a_sel  = A_XAX;
				cmd.a_comp = rot_comp(coord_q, 2'd2);
				cmd.b_sel  = B_YAX;
				cmd.b_comp = rot_comp(coord_q, 2'd1);
				cmd.acc_op = ACC_SUB;
				state_nx   = S_CDRAIN;
			end
			S_CDRAIN: begin
				state_nx = S_CROUND;
			end
			S_CROUND: begin
				cmd.third_ld = 1'b1;
				if (coord_q != LAST_COMP) begin
					coord_nx = coord_q + 2'd1;
					state_nx = S_CMUL0;
				end else begin
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

endmodule

### hdl/affine_transform_bounding_box.sv
// ----------------------------------------------------------------------------
// affine_transform_bounding_box
// Axis-aligned bounding box of a mesh after a scaled rotation and translation.
// ----------------------------------------------------------------------------
// Usage: vertices arrive on the vertex channel, one Q16.16 vertex per item,
// with final_vertex set on the last vertex of a mesh. Each vertex is mapped to
// scale * (px*X + py*Y + pz*(X cross Y)) + shift, and the running minimum and
// maximum of every coordinate are kept, starting from +1000.0 and -1000.0.
// The item that carries final_vertex produces one item on the box channel with
// the six bounds, that vertex included, and the bounds start over.
// One shared 32x16 multiplier serves all nine dot-product terms and the
// three scale steps. A vertex occupies the block until its third coordinate
// has passed the multiply, drain, round, scale, shift and update steps, and
// the next vertex is taken only once the block is back in idle. A vertex
// that closes a mesh adds the emit step, in which its result is registered
// as valid once the output register is free.
// The result sits in an output register; the next mesh keeps streaming while
// it waits. Only when a second result is ready while the first is still not
// taken does the block hold the vertex channel until the box channel drains.
// Configuration writes are taken while no vertex is in flight. A write to
// either axis starts a cross product on the same multiplier, during
// which neither channel is ready. Reset loads the default registers
// (identity axes, unit scale, zero shift) and the initial bounds.
// ----------------------------------------------------------------------------
module affine_transform_bounding_box import atbb_pkg::*; (
	input logic           clk,
	input logic           arst_n,
	atbb_vertex_if.sink   vertex,
	atbb_box_if.source    box,
	atbb_cfg_if.sink      cfg
);

	atbb_cmd_t                cmd;
	atbb_status_t             status;
	logic                     cfg_we;
	logic signed [DATA_W-1:0] low [3];
	logic signed [DATA_W-1:0] high [3];

	// A register write completes on the configuration handshake.
	assign cfg_we = cfg.valid && cfg.ready;

	// The controller owns both ready signals and sequences the datapath.
	atbb_controller u_controller (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vertex.valid),
		.in_ready  (vertex.ready),
		.cfg_valid (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_ready (cfg.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// The datapath holds the registers, the multiplier and the result slot.
	atbb_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.cfg_we    (cfg_we),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.in_x      (vertex.vertex_x),
		.in_y      (vertex.vertex_y),
		.in_z      (vertex.vertex_z),
		.in_final  (vertex.final_vertex),
		.out_ready (box.ready),
		.out_valid (box.valid),
		.low       (low),
		.high      (high)
	);

	// Bounds are presented in x, y, z order.
	assign box.low_x  = low[0];
	assign box.low_y  = low[1];
	assign box.low_z  = low[2];
	assign box.high_x = high[0];
	assign box.high_y = high[1];
	assign box.high_z = high[2];

endmodule

### hdl/atbb_checker.sv
// ----------------------------------------------------------------------------
// atbb_checker
// Port-level checks on the bounding box block, bound to the top level.
// ----------------------------------------------------------------------------
`include "affine_transform_bounding_box_defines.svh"

module atbb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        cfg_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] out_low_x,
	input logic [31:0] out_high_z
);

	// A vertex is worked on alone, so the vertex channel closes after an accept.
	`ATBB_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

	// Vertices are only taken while configuration writes are also open.
	`ATBB_ASSERT_NOW(a_ready_implies_cfg, in_ready, cfg_ready)

	// A new result is loaded only from the emit step, never from idle.
	`ATBB_ASSERT_NOW(a_emit_not_idle, $rose(out_valid), !$past(in_ready))

	// A stalled result holds.
	`ATBB_ASSERT_NEXT(a_result_holds, out_valid && !out_ready,
		out_valid && $stable(out_low_x) && $stable(out_high_z))

endmodule

bind affine_transform_bounding_box atbb_checker u_atbb_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (vertex.valid),
	.in_ready   (vertex.ready),
	.cfg_ready  (cfg.ready),
	.out_valid  (box.valid),
	.out_ready  (box.ready),
	.out_low_x  (box.low_x),
	.out_high_z (box.high_z)
);

### tb/tb_affine_transform_bounding_box.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_affine_transform_bounding_box
// Self-checking bench for the bounding box of a transformed vertex stream.
// A short table of vertices runs at the reset setting, partly with the boxes
// typed in. Then eight random segments follow, each under a new register
// setting and a new pacing of both channels. Every box item is compared,
// field by field, with a typed box or a bit-exact fixed-point bench predictor.
// ----------------------------------------------------------------------------
module tb_affine_transform_bounding_box;
	import atbb_pkg::*;

	localparam int                       Q_ONE          = 65536;
	localparam logic signed [DATA_W-1:0] S32_MAX        = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] S32_MIN        = 32'sh8000_0000;
	localparam longint                   SAT32_HI       = 64'sd2147483647;
	localparam longint                   SAT32_LO       = -64'sd2147483648;
	localparam longint                   SAT16_HI       = 64'sd32767;
	localparam longint                   SAT16_LO       = -64'sd32768;
	localparam logic signed [COMP_W-1:0] COMP_MAX       = 16'sh7FFF;
	localparam logic signed [COMP_W-1:0] COMP_MIN       = 16'sh8000;
	// Register indexes that the block does not implement.
	localparam logic [CFG_IDX_W-1:0]     CFG_SPARE_A    = 3'd6;
	localparam logic [CFG_IDX_W-1:0]     CFG_SPARE_B    = 3'd7;
	localparam int                       NUM_SEGMENTS   = 8;
	localparam int                       ITEMS_PER_SEG  = 180;
	// Long enough for a vertex and an axis write after it to finish.
	localparam int                       SETTLE_CYCLES  = 64;
	localparam int                       MAX_REPORTS    = 10;
	localparam longint                   RUN_LIMIT_NS   = 64'd20_000_000;

	typedef struct packed {
		logic signed [DATA_W-1:0] vx;
		logic signed [DATA_W-1:0] vy;
		logic signed [DATA_W-1:0] vz;
		logic                     fin;
	} vertex_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] lo_x;
		logic signed [DATA_W-1:0] lo_y;
		logic signed [DATA_W-1:0] lo_z;
		logic signed [DATA_W-1:0] hi_x;
		logic signed [DATA_W-1:0] hi_y;
		logic signed [DATA_W-1:0] hi_z;
	} box_t;

	// A row of the directed table: the vertex, and the box it must close with
	// where that box is plain to see (chk set).
	typedef struct packed {
		vertex_t v;
		logic    chk;
		box_t    want;
	} dir_row_t;

	typedef enum {PACE_FREE, PACE_SRC, PACE_SNK, PACE_BOTH} pace_t;

	// All rows run at the reset setting, where the transform is the identity,
	// so each box is just the running extremes of the raw coordinates.
	localparam dir_row_t DIR_ROWS [0:12] = '{
		// Vertex at the origin closes a mesh of one: the box collapses to zero.
		'{'{32'sd0, 32'sd0, 32'sd0, 1'b1}, 1'b1, '0},
		// Coordinate extremes: one bound moves, the other keeps its start value.
		'{'{S32_MAX, S32_MIN, 32'sd0, 1'b1}, 1'b1,
			'{INIT_MIN, S32_MIN, 32'sd0, S32_MAX, INIT_MAX, 32'sd0}},
		'{'{S32_MIN, S32_MAX, -32'sd1, 1'b1}, 1'b1,
			'{S32_MIN, INIT_MIN, -32'sd1, INIT_MAX, S32_MAX, -32'sd1}},
		'{'{Q_ONE, -Q_ONE, Q_ONE / 2, 1'b1}, 1'b1,
			'{Q_ONE, -Q_ONE, Q_ONE / 2, Q_ONE, -Q_ONE, Q_ONE / 2}},
		// A three-vertex mesh.
		'{'{5 * Q_ONE, 32'sd0, 32'sd0, 1'b0}, 1'b0, '0},
		'{'{-3 * Q_ONE, 2 * Q_ONE, 32'sd0, 1'b0}, 1'b0, '0},
		'{'{32'sd0, 32'sd0, 7 * Q_ONE, 1'b1}, 1'b1,
			'{-3 * Q_ONE, 32'sd0, 32'sd0, 5 * Q_ONE, 2 * Q_ONE, 7 * Q_ONE}},
		// Exactly on the start values of the bounds.
		'{'{1000 * Q_ONE, -1000 * Q_ONE, 32'sd0, 1'b1}, 1'b1,
			'{INIT_MIN, INIT_MAX, 32'sd0, INIT_MIN, INIT_MAX, 32'sd0}},
		// Vertices beyond the start values, checked by the predictor.
		'{'{1500 * Q_ONE, -2000 * Q_ONE, 32'sd1, 1'b0}, 1'b0, '0},
		'{'{-32'sd1, 32'sd1, S32_MAX, 1'b0}, 1'b0, '0},
		'{'{32'sh5555_5555, 32'shAAAA_AAAA, 32'sh1234_5678, 1'b1}, 1'b0, '0},
		'{'{S32_MIN, S32_MIN, S32_MIN, 1'b0}, 1'b0, '0},
		'{'{S32_MAX, S32_MAX, S32_MAX, 1'b1}, 1'b0, '0}
	};

	logic clk;
	logic arst_n;

	atbb_vertex_if vertex_ch ();
	atbb_box_if    box_ch ();
	atbb_cfg_if    cfg_ch ();

	affine_transform_bounding_box dut (
		.clk    (clk),
		.arst_n (arst_n),
		.vertex (vertex_ch),
		.box    (box_ch),
		.cfg    (cfg_ch)
	);

	// Predictor state: the register copy, the derived third axis and the
	// running bounds of the mesh in progress.
	logic [AXIS_W-1:0]        cur_x_axis;
	logic [AXIS_W-1:0]        cur_y_axis;
	logic [AXIS_W-1:0]        cur_z_axis;
	logic signed [COMP_W-1:0] cur_scale;
	logic signed [DATA_W-1:0] cur_shift [3];
	logic signed [DATA_W-1:0] run_lo [3];
	logic signed [DATA_W-1:0] run_hi [3];

	box_t  expected_boxes [$];
	int    fail_count;
	int    src_gap_pct;
	int    snk_stall_pct;
	string FIELD_NAME [6] = '{"low_x", "low_y", "low_z", "high_x", "high_y", "high_z"};

	// ------------------------------------------------------------------
	// Fixed-point helpers of the predictor
	// ------------------------------------------------------------------
	function automatic longint axis_comp(logic [AXIS_W-1:0] axis, int i);
		logic signed [COMP_W-1:0] c;
		c = axis[COMP_W*i +: COMP_W];
		return longint'(c);
	endfunction

	// Add half an LSB of the result, then floor.
	function automatic longint round_half_up(longint v, int k);
		return (v + (longint'(1) << (k - 1))) >>> k;
	endfunction

	function automatic longint clamp(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic logic [AXIS_W-1:0] cross_axes(logic [AXIS_W-1:0] a,
		logic [AXIS_W-1:0] b);
		longint            c [3];
		longint            t;
		logic [AXIS_W-1:0] r;
		c[0] = axis_comp(a, 1) * axis_comp(b, 2) - axis_comp(a, 2) * axis_comp(b, 1);
		c[1] = axis_comp(a, 2) * axis_comp(b, 0) - axis_comp(a, 0) * axis_comp(b, 2);
		c[2] = axis_comp(a, 0) * axis_comp(b, 1) - axis_comp(a, 1) * axis_comp(b, 0);
		for (int i = 0; i < 3; i++) begin
			t = clamp(round_half_up(c[i], AXIS_FRAC), SAT16_LO, SAT16_HI);
			r[COMP_W*i +: COMP_W] = t[COMP_W-1:0];
		end
		return r;
	endfunction

	// One transformed coordinate: dot product with row i of the axis matrix,
	// then scale, then shift, each step saturated to 32 bits.
	function automatic logic signed [DATA_W-1:0] map_coord(vertex_t v, int i);
		longint acc;
		acc = longint'($signed(v.vx)) * axis_comp(cur_x_axis, i)
			+ longint'($signed(v.vy)) * axis_comp(cur_y_axis, i)
			+ longint'($signed(v.vz)) * axis_comp(cur_z_axis, i);
		acc = clamp(round_half_up(acc, AXIS_FRAC), SAT32_LO, SAT32_HI);
		acc = clamp(round_half_up(acc * longint'(cur_scale), SCALE_FRAC), SAT32_LO, SAT32_HI);
		acc = clamp(acc + longint'(cur_shift[i]), SAT32_LO, SAT32_HI);
		return acc[DATA_W-1:0];
	endfunction

	function automatic void restart_bounds();
		for (int i = 0; i < 3; i++) begin
			run_lo[i] = INIT_MIN;
			run_hi[i] = INIT_MAX;
		end
	endfunction

	// Folds one accepted vertex into the running bounds. Returns 1 with the
	// closed box when the vertex ends its mesh.
	function automatic bit fold_vertex(vertex_t v, output box_t b);
		logic signed [DATA_W-1:0] t;
		for (int i = 0; i < 3; i++) begin
			t = map_coord(v, i);
			if (t < run_lo[i]) run_lo[i] = t;
			if (t > run_hi[i]) run_hi[i] = t;
		end
		b = '{run_lo[0], run_lo[1], run_lo[2], run_hi[0], run_hi[1], run_hi[2]};
		if (!v.fin)
			return 1'b0;
		restart_bounds();
		return 1'b1;
	endfunction

	function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		case (cfg_idx_t'(idx))
			CFG_X_AXIS: begin
				cur_x_axis = d;
				cur_z_axis = cross_axes(cur_x_axis, cur_y_axis);
			end
			CFG_Y_AXIS: begin
				cur_y_axis = d;
				cur_z_axis = cross_axes(cur_x_axis, cur_y_axis);
			end
			CFG_SCALE:   cur_scale    = d[COMP_W-1:0];
			CFG_SHIFT_X: cur_shift[0] = d[DATA_W-1:0];
			CFG_SHIFT_Y: cur_shift[1] = d[DATA_W-1:0];
			CFG_SHIFT_Z: cur_shift[2] = d[DATA_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic logic signed [DATA_W-1:0] field_of(box_t b, int i);
		case (i)
			0: return b.lo_x;
			1: return b.lo_y;
			2: return b.lo_z;
			3: return b.hi_x;
			4: return b.hi_y;
			default: return b.hi_z;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Random content
	// ------------------------------------------------------------------
	// Signed value spread evenly over -m .. m.
	function automatic int spread(int m);
		return int'($urandom_range(0, 2 * m)) - m;
	endfunction

	// Coordinates lean toward the range where the bounds really move, with
	// some full-width and extreme values so that saturation gets exercised.
	function automatic logic signed [DATA_W-1:0] rand_coord();
		int k;
		k = $urandom_range(99);
		if (k < 60)
			return spread(1 << 26);
		if (k < 75)
			return $urandom();
		if (k < 88)
			return spread(1 << 17);
		case ($urandom_range(3))
			0: return S32_MIN;
			1: return S32_MAX;
			2: return 32'sd0;
			default: return -32'sd1;
		endcase
	endfunction

	function automatic logic [AXIS_W-1:0] pack_axis(logic signed [COMP_W-1:0] cx,
		logic signed [COMP_W-1:0] cy, logic signed [COMP_W-1:0] cz);
		return {cz, cy, cx};
	endfunction

	// Axis with components within +-1.0, the range of a true rotation.
	function automatic logic [AXIS_W-1:0] unit_axis();
		return pack_axis(COMP_W'(spread(1 << AXIS_FRAC)), COMP_W'(spread(1 << AXIS_FRAC)),
			COMP_W'(spread(1 << AXIS_FRAC)));
	endfunction

	function automatic logic [CFG_DATA_W-1:0] rand_data();
		return CFG_DATA_W'({$urandom(), $urandom()});
	endfunction

	// ------------------------------------------------------------------
	// Failure reporting: only the first few are printed.
	// ------------------------------------------------------------------
	task automatic flag(string what);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("%0t ns: %s", $time, what);
	endtask

	// ------------------------------------------------------------------
	// Clock, reset and the limit on the whole run
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("timeout: %0d box items still pending", expected_boxes.size());
		$display("Mismatches found");
		$finish;
	end

	// ------------------------------------------------------------------
	// Box channel: ready is redrawn at every falling edge according to the
	// current stall rate; items are taken and checked at the rising edge.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		box_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
	end

	always @(posedge clk) begin : box_monitor
		box_t got;
		box_t want;
		if (arst_n && box_ch.valid && box_ch.ready) begin
			got = '{box_ch.low_x, box_ch.low_y, box_ch.low_z,
				box_ch.high_x, box_ch.high_y, box_ch.high_z};
			if (expected_boxes.size() == 0) begin
				flag($sformatf("box item with nothing pending: low %0d %0d %0d high %0d %0d %0d",
					got.lo_x, got.lo_y, got.lo_z, got.hi_x, got.hi_y, got.hi_z));
			end else begin
				want = expected_boxes.pop_front();
				for (int i = 0; i < 6; i++) begin
					if (field_of(got, i) !== field_of(want, i))
						flag($sformatf("box field %s: expected %0d (0x%08h), got %0d (0x%08h)",
							FIELD_NAME[i], field_of(want, i), field_of(want, i),
							field_of(got, i), field_of(got, i)));
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Driving tasks. Each one is entered right after a falling edge and
	// returns right after a falling edge, so the vertex and configuration
	// inputs only ever change there.
	// ------------------------------------------------------------------
	task automatic set_pace(pace_t p);
		case (p)
			PACE_FREE: begin src_gap_pct = 0;  snk_stall_pct = 0;  end
			PACE_SRC:  begin src_gap_pct = 45; snk_stall_pct = 0;  end
			PACE_SNK:  begin src_gap_pct = 0;  snk_stall_pct = 45; end
			default:   begin src_gap_pct = 8;  snk_stall_pct = 8;  end
		endcase
	endtask

	// Offers one vertex, after a random gap, and holds it until it is taken.
	// At the accept edge the predictor folds it in; a vertex that closes a
	// mesh queues its box, the typed one where the table gives it.
	task automatic push_vertex(vertex_t v, bit typed, box_t typed_box);
		box_t predicted;
		while ($urandom_range(99) < src_gap_pct) begin
			vertex_ch.valid <= 1'b0;
			@(negedge clk);
		end
		vertex_ch.valid        <= 1'b1;
		vertex_ch.vertex_x     <= v.vx;
		vertex_ch.vertex_y     <= v.vy;
		vertex_ch.vertex_z     <= v.vz;
		vertex_ch.final_vertex <= v.fin;
		do @(posedge clk); while (!vertex_ch.ready);
		if (fold_vertex(v, predicted))
			expected_boxes.push_back(typed ? typed_box : predicted);
		@(negedge clk);
	endtask

	// One register write. Valid stays high across a batch of writes; the
	// caller lowers it after the last one.
	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= d;
		do @(posedge clk); while (!cfg_ch.ready);
		apply_cfg(idx, d);
		@(negedge clk);
	endtask

	// Registers are only written with the block idle: every box in, then
	// enough cycles for a vertex that closes no mesh to finish as well.
	task automatic wait_idle();
		while (expected_boxes.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Register setting of one random segment. The upper data bits of the
	// narrow registers carry noise, which the block must not use.
	task automatic program_setting(int seg);
		logic [CFG_DATA_W-1:0]    xa;
		logic [CFG_DATA_W-1:0]    ya;
		logic signed [COMP_W-1:0] sc;
		logic signed [DATA_W-1:0] sh [3];
		case (seg)
			0: begin
				xa = unit_axis();
				ya = unit_axis();
				sc = COMP_W'($urandom_range(64, 512));
				for (int i = 0; i < 3; i++) sh[i] = spread(1 << 24);
			end
			1: begin
				// Largest components everywhere: the cross product saturates.
				xa = pack_axis(COMP_MAX, COMP_MAX, COMP_MAX);
				ya = pack_axis(COMP_MIN, COMP_MAX, COMP_MIN);
				sc = COMP_MAX;
				for (int i = 0; i < 3; i++) sh[i] = S32_MAX;
			end
			2: begin
				xa = pack_axis(COMP_MIN, COMP_MIN, COMP_MIN);
				ya = pack_axis(COMP_MAX, COMP_MIN, COMP_MAX);
				sc = COMP_MIN;
				for (int i = 0; i < 3; i++) sh[i] = S32_MIN;
			end
			3: begin
				xa = rand_data();
				ya = rand_data();
				sc = COMP_W'($urandom());
				for (int i = 0; i < 3; i++) sh[i] = $urandom();
			end
			4: begin
				// Zero scale flattens every vertex onto the shift.
				xa = unit_axis();
				ya = unit_axis();
				sc = '0;
				for (int i = 0; i < 3; i++) sh[i] = $urandom();
			end
			5: begin
				xa = rand_data();
				ya = rand_data();
				sc = COMP_W'(-$urandom_range(1, 512));
				for (int i = 0; i < 3; i++) sh[i] = spread(1 << 26);
			end
			6: begin
				xa = unit_axis();
				ya = unit_axis();
				sc = COMP_W'($urandom());
				for (int i = 0; i < 3; i++) sh[i] = '0;
			end
			default: begin
				// Back to the reset registers, with a random shift.
				xa = X_AXIS_RESET;
				ya = Y_AXIS_RESET;
				sc = SCALE_RESET;
				for (int i = 0; i < 3; i++) sh[i] = spread(1 << 26);
			end
		endcase
		cfg_write(CFG_X_AXIS, xa);
		cfg_write(CFG_Y_AXIS, ya);
		cfg_write(CFG_SCALE, {$urandom(), sc});
		cfg_write(CFG_SHIFT_X, {16'($urandom()), sh[0]});
		cfg_write(CFG_SHIFT_Y, {16'($urandom()), sh[1]});
		cfg_write(CFG_SHIFT_Z, {16'($urandom()), sh[2]});
		// Writes to indexes with no register behind them must change nothing.
		if (seg == 3) begin
			cfg_write(CFG_SPARE_A, rand_data());
			cfg_write(CFG_SPARE_B, rand_data());
		end
		cfg_ch.valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin : main_seq
		int      sent;
		int      fin_pct;
		vertex_t v;

		vertex_ch.valid        = 1'b0;
		vertex_ch.vertex_x     = '0;
		vertex_ch.vertex_y     = '0;
		vertex_ch.vertex_z     = '0;
		vertex_ch.final_vertex = 1'b0;
		box_ch.ready           = 1'b0;
		cfg_ch.valid           = 1'b0;
		cfg_ch.index           = '0;
		cfg_ch.data            = '0;
		fail_count             = 0;
		set_pace(PACE_FREE);

		// Predictor after reset: identity axes, unit scale, zero shift.
		cur_x_axis = X_AXIS_RESET;
		cur_y_axis = Y_AXIS_RESET;
		cur_z_axis = cross_axes(cur_x_axis, cur_y_axis);
		cur_scale  = SCALE_RESET;
		for (int i = 0; i < 3; i++) cur_shift[i] = '0;
		restart_bounds();

		arst_n = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed table at the reset setting.
		for (int n = 0; n < $size(DIR_ROWS); n++)
			push_vertex(DIR_ROWS[n].v, DIR_ROWS[n].chk, DIR_ROWS[n].want);
		vertex_ch.valid <= 1'b0;

		// Random segments. Each one takes a new setting and a new pacing;
		// the mesh length varies with the chance of a closing vertex. A
		// segment may stop inside a mesh, which then carries its bounds
		// across the register writes into the next segment.
		for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
			set_pace(pace_t'(seg % 4));
			wait_idle();
			program_setting(seg);
			case (seg % 3)
				0: fin_pct = 30;
				1: fin_pct = 15;
				default: fin_pct = 6;
			endcase
			for (sent = 0; sent < ITEMS_PER_SEG; sent++) begin
				v.vx  = rand_coord();
				v.vy  = rand_coord();
				v.vz  = rand_coord();
				v.fin = ($urandom_range(99) < fin_pct);
				push_vertex(v, 1'b0, '0);
			end
			vertex_ch.valid <= 1'b0;
		end

		// Drain: every pending box must arrive, then the block must stay quiet.
		while (expected_boxes.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (fail_count == 0 && expected_boxes.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
